FILE: hw/rtl/fpl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpl_pkg
// Shared types and constants of the file popularity table.
// ----------------------------------------------------------------------------
package fpl_pkg;

    localparam int FID_W  = 64;
    localparam int MT_W   = 63;
    localparam int CNT_W  = 32;
    localparam int SLOT_W = 4;

    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 40;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [FID_W-1:0] fid;
        logic [MT_W-1:0]  mt;
        logic [CNT_W-1:0] cnt;
    } t_entry;

    typedef struct packed {
        logic start;
        logic search;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic decided;
        logic out_free;
    } t_dp_stat;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_FINISH = 3'b100
    } t_state;

endpackage
`default_nettype wire

FILE: hw/rtl/file_popularity_lfu_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// file_popularity_lfu_table
// Least-frequently-used table of file access counts with a cached-file mark.
// ----------------------------------------------------------------------------
// Search: one entry memory read per cycle, in entry order; it ends at a hit,
// at the first empty entry (a fill), or, once every entry has been read with
// no match, at a miss that evicts the entry with the lowest count. One item at
// a time: the next input beat is taken only after the result is committed to
// the output register; a result still held in the output register stalls.
// Reset: synchronous; the table is empty and the cache mark cleared at once.
// ----------------------------------------------------------------------------
module file_popularity_lfu_table
    import fpl_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_tvalid,
    output logic                   o_s_tready,
    // file_id [63:0], mod_time [126:64], zero [127]
    input  wire [IN_DATA_W-1:0]    i_s_tdata,
    output logic                   o_m_tvalid,
    input  wire                    i_m_tready,
    // hit [0], slot [4:1], access_count [36:5], evicted [37],
    // refill_cache [38], serve_from_cache [39]
    output logic [OUT_DATA_W-1:0]  o_m_tdata
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    fpl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fpl_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_fid       (i_s_tdata[FID_W-1:0]),
        .i_mt        (i_s_tdata[FID_W+MT_W-1:FID_W]),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_data  (o_m_tdata)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/fpl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpl_ctrl
// Sequencer of the file popularity table: accept, search, commit.
// ----------------------------------------------------------------------------
module fpl_ctrl
    import fpl_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_ready,
    input  t_dp_stat  i_stat,
    output t_dp_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.start  = 1'b0;
        o_cmd.search = 1'b0;
        o_cmd.commit = 1'b0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = i_rst_n;
                o_cmd.start = i_in_valid && i_rst_n;
                if (i_in_valid) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_stat.decided) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.commit = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/fpl_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpl_datapath
// Entry memory, in-order search with running minimum, cache mark and result.
// ----------------------------------------------------------------------------
module fpl_datapath
    import fpl_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    input  wire [FID_W-1:0]        i_fid,
    input  wire [MT_W-1:0]         i_mt,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output logic [OUT_DATA_W-1:0]  o_out_data
);

    localparam int IW    = $clog2(ENTRIES);
    localparam int PTR_W = IW + 1;

    typedef enum logic [1:0] {
        K_HIT   = 2'b00,
        K_FILL  = 2'b01,
        K_EVICT = 2'b10
    } t_kind;

    t_entry             mem [ENTRIES];

    logic [FID_W-1:0]   r_fid;
    logic [MT_W-1:0]    r_mt;
    logic [PTR_W-1:0]   r_ptr;
    logic               r_rd_vld;
    logic [IW-1:0]      r_rd_idx;
    t_entry             r_rd_word;
    logic [CNT_W-1:0]   r_min_cnt;
    logic [IW-1:0]      r_min_idx;
    logic [ENTRIES-1:0] r_valid;
    logic               r_cache_valid;
    logic [IW-1:0]      r_cache_slot;
    logic [CNT_W-1:0]   r_cache_cnt;
    t_kind              r_kind;
    logic [IW-1:0]      r_slot;
    logic [CNT_W-1:0]   r_cnt;

    logic               r_o_valid;
    logic               r_o_hit;
    logic [SLOT_W-1:0]  r_o_slot;
    logic [CNT_W-1:0]   r_o_cnt;
    logic               r_o_evicted;
    logic               r_o_refill;
    logic               r_o_serve;

    logic               ptr_in;
    logic [IW-1:0]      issue_idx;
    logic               cmp_match;
    logic               empty_here;
    logic               full_miss;
    logic               decided;
    logic               issue;
    logic [CNT_W-1:0]   cur_min_cnt;
    logic [IW-1:0]      cur_min_idx;
    logic [CNT_W-1:0]   new_cnt;
    logic               same_slot;
    logic               refill;
    logic               serve;
    t_kind              n_kind;
    logic [IW-1:0]      n_slot;

    assign ptr_in     = r_ptr < PTR_W'(ENTRIES);
    assign issue_idx  = r_ptr[IW-1:0];
    assign cmp_match  = r_rd_vld && (r_rd_word.fid == r_fid) && (r_rd_word.mt == r_mt);
    assign empty_here = ptr_in && !r_valid[issue_idx];
    assign full_miss  = !ptr_in && r_rd_vld && !cmp_match;
    assign decided    = cmp_match || empty_here || full_miss;
    assign issue      = i_cmd.search && ptr_in && r_valid[issue_idx] && !cmp_match;

    always_comb begin
        cur_min_cnt = r_min_cnt;
        cur_min_idx = r_min_idx;
        if (r_rd_vld && ((r_rd_idx == '0) || (r_rd_word.cnt < r_min_cnt))) begin
            cur_min_cnt = r_rd_word.cnt;
            cur_min_idx = r_rd_idx;
        end
    end

    always_comb begin
        priority if (cmp_match) begin
            n_kind = K_HIT;
            n_slot = r_rd_idx;
        end else if (empty_here) begin
            n_kind = K_FILL;
            n_slot = issue_idx;
        end else begin
            n_kind = K_EVICT;
            n_slot = cur_min_idx;
        end
    end

    always_comb begin
        if (r_kind == K_HIT) begin
            new_cnt = (r_cnt == CNT_MAX) ? CNT_MAX : r_cnt + CNT_W'(1);
        end else begin
            new_cnt = CNT_W'(1);
        end
    end

    assign same_slot = r_cache_slot == r_slot;
    assign refill    = !r_cache_valid ||
                       ((r_kind != K_EVICT) && !same_slot && (new_cnt > r_cache_cnt));
    assign serve     = refill || (r_cache_valid && same_slot && (r_kind != K_EVICT));

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_word <= mem[issue_idx];
        end
        if (i_cmd.commit) begin
            mem[r_slot] <= '{fid: r_fid, mt: r_mt, cnt: new_cnt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_fid <= i_fid;
            r_mt  <= i_mt;
            r_ptr <= '0;
        end else if (issue) begin
            r_ptr <= r_ptr + PTR_W'(1);
        end
        if (issue) begin
            r_rd_idx <= issue_idx;
        end
        if (i_cmd.search) begin
            r_min_cnt <= cur_min_cnt;
            r_min_idx <= cur_min_idx;
        end
        if (i_cmd.search && decided) begin
            r_kind <= n_kind;
            r_slot <= n_slot;
            r_cnt  <= r_rd_word.cnt;
        end
        if (i_cmd.commit) begin
            r_o_hit     <= r_kind == K_HIT;
            r_o_slot    <= SLOT_W'(r_slot);
            r_o_cnt     <= new_cnt;
            r_o_evicted <= r_kind == K_EVICT;
            r_o_refill  <= refill;
            r_o_serve   <= serve;
            if (refill || same_slot) begin
                r_cache_cnt <= new_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld      <= 1'b0;
            r_valid       <= '0;
            r_cache_valid <= 1'b0;
            r_cache_slot  <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            if (i_cmd.commit) begin
                r_valid[r_slot] <= 1'b1;
                if (refill) begin
                    r_cache_valid <= 1'b1;
                    r_cache_slot  <= r_slot;
                end else if ((r_kind == K_EVICT) && same_slot) begin
                    r_cache_valid <= 1'b0;
                end
            end
            if (i_cmd.commit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_stat.decided  = decided;
    assign o_stat.out_free = !r_o_valid || i_out_ready;

    assign o_out_valid = r_o_valid;
    assign o_out_data  = {r_o_serve, r_o_refill, r_o_evicted, r_o_cnt, r_o_slot, r_o_hit};

endmodule
`default_nettype wire
